// ----- hdl/gci_pkg.sv -----
// ----------------------------------------------------------------------------
// Great-circle intersection package
// Shared widths, fixed-point constants, the arctangent table and the sideband
// types that ride along the vectoring CORDIC stages.
// ----------------------------------------------------------------------------
package gci_pkg;

    localparam int CORDIC_STEPS = 30;

    // Vector components, normalized direction components and Q.30 angles.
    localparam int VW = 34;
    localparam int DW = 36;
    localparam int AW = 35;

    typedef logic signed [VW-1:0] vec_t;
    typedef logic signed [DW-1:0] dvec_t;
    typedef logic signed [AW-1:0] ang_t;

    localparam logic [33:0] Q_TWO_PI   = 34'd6746518852;
    localparam ang_t        Q_ONE_PI   = 35'sd3373259426;
    localparam ang_t        Q_HALF_PI  = 35'sd1686629713;
    localparam logic [30:0] Q_INV_GAIN = 31'd652032874;

    // Direction sideband into the azimuth CORDIC, and into the polar CORDIC.
    typedef struct packed {
        logic  deg;
        dvec_t z;
    } side_az_t;

    typedef struct packed {
        logic deg;
        ang_t phi;
    } side_po_t;

    function automatic ang_t atan_tab(input int unsigned idx);
        ang_t r;
        case (idx)
            0:       r = 35'sd843314856;
            1:       r = 35'sd497837829;
            2:       r = 35'sd263043836;
            3:       r = 35'sd133525158;
            4:       r = 35'sd67021686;
            5:       r = 35'sd33543515;
            6:       r = 35'sd16775850;
            7:       r = 35'sd8388437;
            8:       r = 35'sd4194282;
            9:       r = 35'sd2097149;
            10:      r = 35'sd1048575;
            11:      r = 35'sd524287;
            12:      r = 35'sd262143;
            13:      r = 35'sd131071;
            14:      r = 35'sd65535;
            15:      r = 35'sd32767;
            16:      r = 35'sd16383;
            17:      r = 35'sd8191;
            18:      r = 35'sd4095;
            19:      r = 35'sd2047;
            20:      r = 35'sd1023;
            21:      r = 35'sd511;
            22:      r = 35'sd255;
            23:      r = 35'sd127;
            24:      r = 35'sd63;
            25:      r = 35'sd31;
            26:      r = 35'sd15;
            27:      r = 35'sd7;
            28:      r = 35'sd3;
            29:      r = 35'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/gci_angle_reduce.sv -----
// ----------------------------------------------------------------------------
// Angle reduction
// Scales an input angle to Q.30, reduces it modulo 2*pi with one
// compare-and-subtract per stage, then folds it into [-pi/2, pi/2].
// ----------------------------------------------------------------------------
module gci_angle_reduce #(
    parameter int IN_W   = 31,
    parameter int FRAC   = 28,
    parameter int STAGES = 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [IN_W-1:0]  angle,
    output gci_pkg::ang_t    z_out,
    output logic             neg_out
);

    localparam int UPP = (30 - FRAC > 0) ? 30 - FRAC : 0;
    localparam int DNN = (FRAC - 30 > 0) ? FRAC - 30 : 0;
    localparam int RW  = (IN_W + UPP + 1 > 34) ? IN_W + UPP + 1 : 34;

    logic [RW-1:0]  red_reg [STAGES+1];
    logic [RW-1:0]  shifted;
    gci_pkg::ang_t  z_reg, z_next;
    logic           neg_reg, neg_next;

    assign shifted = (RW'(angle) << UPP) >> DNN;

    always_ff @(posedge aclk) begin
        if (en) begin
            red_reg[0] <= shifted;
        end
    end

    // Stage j removes 2*pi times 2^k with k counting down; the value always
    // stays below twice the next subtrahend.
    for (genvar j = 0; j < STAGES; j++) begin : g_red
        localparam logic [RW-1:0] SUB = RW'(64'(gci_pkg::Q_TWO_PI) << (STAGES - 1 - j));
        always_ff @(posedge aclk) begin
            if (en) begin
                red_reg[j+1] <= (red_reg[j] >= SUB) ? red_reg[j] - SUB : red_reg[j];
            end
        end
    end

    always_comb begin
        gci_pkg::ang_t zv;
        zv       = gci_pkg::ang_t'(red_reg[STAGES]);
        neg_next = 1'b0;
        if (zv > gci_pkg::Q_ONE_PI) begin
            zv = zv - gci_pkg::ang_t'(gci_pkg::Q_TWO_PI);
        end
        if (zv > gci_pkg::Q_HALF_PI) begin
            zv       = zv - gci_pkg::Q_ONE_PI;
            neg_next = 1'b1;
        end else if (zv < -gci_pkg::Q_HALF_PI) begin
            zv       = zv + gci_pkg::Q_ONE_PI;
            neg_next = 1'b1;
        end
        z_next = zv;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg   <= z_next;
            neg_reg <= neg_next;
        end
    end

    assign z_out   = z_reg;
    assign neg_out = neg_reg;

endmodule

// ----- hdl/gci_sincos.sv -----
// ----------------------------------------------------------------------------
// Sine and cosine
// Rotation CORDIC with one register stage per iteration and a final stage
// that undoes the half-turn fold.
// ----------------------------------------------------------------------------
module gci_sincos (
    input  logic           aclk,
    input  logic           en,
    input  gci_pkg::ang_t  z_in,
    input  logic           neg_in,
    output gci_pkg::vec_t  cos_out,
    output gci_pkg::vec_t  sin_out
);

    localparam int N = gci_pkg::CORDIC_STEPS;

    gci_pkg::vec_t x_reg [N];
    gci_pkg::vec_t y_reg [N];
    gci_pkg::ang_t z_reg [N];
    logic          n_reg [N];
    gci_pkg::vec_t c_reg, s_reg;

    for (genvar i = 0; i < N; i++) begin : g_step
        gci_pkg::vec_t xi, yi;
        gci_pkg::ang_t zi;
        logic          ni;
        if (i == 0) begin : g_first
            assign xi = gci_pkg::vec_t'(gci_pkg::Q_INV_GAIN);
            assign yi = '0;
            assign zi = z_in;
            assign ni = neg_in;
        end else begin : g_next
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign ni = n_reg[i-1];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                if (zi >= 0) begin
                    x_reg[i] <= xi - (yi >>> i);
                    y_reg[i] <= yi + (xi >>> i);
                    z_reg[i] <= zi - gci_pkg::atan_tab(i);
                end else begin
                    x_reg[i] <= xi + (yi >>> i);
                    y_reg[i] <= yi - (xi >>> i);
                    z_reg[i] <= zi + gci_pkg::atan_tab(i);
                end
                n_reg[i] <= ni;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg <= n_reg[N-1] ? -x_reg[N-1] : x_reg[N-1];
            s_reg <= n_reg[N-1] ? -y_reg[N-1] : y_reg[N-1];
        end
    end

    assign cos_out = c_reg;
    assign sin_out = s_reg;

endmodule

// ----- hdl/gci_cross.sv -----
// ----------------------------------------------------------------------------
// Cross product
// Six products in the first stage, differences scaled back to Q.30 with
// floor in the second.
// ----------------------------------------------------------------------------
module gci_cross #(
    parameter int IW = 34,
    parameter int OW = 34
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [IW-1:0] a_in [3],
    input  logic signed [IW-1:0] b_in [3],
    output logic signed [OW-1:0] r_out [3]
);

    logic signed [2*IW-1:0] p_reg [6];
    logic signed [OW-1:0]   r_reg [3];

    for (genvar c = 0; c < 3; c++) begin : g_comp
        logic signed [2*IW:0] dif;
        always_ff @(posedge aclk) begin
            if (en) begin
                p_reg[2*c]   <= a_in[(c+1)%3] * b_in[(c+2)%3];
                p_reg[2*c+1] <= a_in[(c+2)%3] * b_in[(c+1)%3];
            end
        end
        assign dif = (2*IW+1)'(p_reg[2*c]) - (2*IW+1)'(p_reg[2*c+1]);
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[c] <= OW'(dif >>> 30);
            end
        end
        assign r_out[c] = r_reg[c];
    end

endmodule

// ----- hdl/gci_vec_cordic.sv -----
// ----------------------------------------------------------------------------
// Vectoring CORDIC
// atan2 and scaled magnitude of (x, y), one register stage per iteration,
// with a pre-rotation by pi for the left half plane.
// ----------------------------------------------------------------------------
module gci_vec_cordic #(
    parameter int SBW = 1
) (
    input  logic            aclk,
    input  logic            en,
    input  gci_pkg::dvec_t  x_in,
    input  gci_pkg::dvec_t  y_in,
    input  logic [SBW-1:0]  sb_in,
    output gci_pkg::ang_t   ang_out,
    output gci_pkg::dvec_t  len_out,
    output logic [SBW-1:0]  sb_out
);

    localparam int N = gci_pkg::CORDIC_STEPS;

    gci_pkg::dvec_t px_reg, py_reg;
    gci_pkg::ang_t  pa_reg;
    logic           pz_reg;
    logic [SBW-1:0] psb_reg;

    gci_pkg::dvec_t x_reg  [N];
    gci_pkg::dvec_t y_reg  [N];
    gci_pkg::ang_t  a_reg  [N];
    logic           zf_reg [N];
    logic [SBW-1:0] sb_reg [N];

    always_ff @(posedge aclk) begin
        if (en) begin
            pz_reg  <= (x_in == '0) && (y_in == '0);
            psb_reg <= sb_in;
            if (x_in < 0) begin
                px_reg <= -x_in;
                py_reg <= -y_in;
                pa_reg <= (y_in >= 0) ? gci_pkg::Q_ONE_PI : -gci_pkg::Q_ONE_PI;
            end else begin
                px_reg <= x_in;
                py_reg <= y_in;
                pa_reg <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        gci_pkg::dvec_t xi, yi;
        gci_pkg::ang_t  ai;
        logic           zi;
        logic [SBW-1:0] si;
        if (i == 0) begin : g_first
            assign xi = px_reg;
            assign yi = py_reg;
            assign ai = pa_reg;
            assign zi = pz_reg;
            assign si = psb_reg;
        end else begin : g_next
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign ai = a_reg[i-1];
            assign zi = zf_reg[i-1];
            assign si = sb_reg[i-1];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                if (yi >= 0) begin
                    x_reg[i] <= xi + (yi >>> i);
                    y_reg[i] <= yi - (xi >>> i);
                    a_reg[i] <= ai + gci_pkg::atan_tab(i);
                end else begin
                    x_reg[i] <= xi - (yi >>> i);
                    y_reg[i] <= yi + (xi >>> i);
                    a_reg[i] <= ai - gci_pkg::atan_tab(i);
                end
                zf_reg[i] <= zi;
                sb_reg[i] <= si;
            end
        end
    end

    // A zero vector has no direction: angle and length read as zero.
    assign ang_out = zf_reg[N-1] ? '0 : a_reg[N-1];
    assign len_out = zf_reg[N-1] ? '0 : x_reg[N-1];
    assign sb_out  = sb_reg[N-1];

endmodule

// ----- hdl/great_circle_intersection.sv -----
// ----------------------------------------------------------------------------
// Great-circle intersection
// Intersection direction of two great circles, each given by two points in
// spherical angles, returned as azimuth and polar angle.
// ----------------------------------------------------------------------------
// Usage: an input transfer on the s_ channel carries the four points (azimuth
// and polar angle each, radians scaled by 2^ANGLE_FRAC_BITS). Each transfer
// yields exactly one output transfer on the m_ channel, in order.
// The path is a fixed pipeline: angle reduction, sine/cosine CORDICs, point
// vectors, two normal cross products, their cross product, normalization,
// an azimuth vectoring CORDIC, a gain multiply and a polar vectoring CORDIC.
// The number of modulo-2*pi subtract stages, R, is 1 at 28 fraction bits,
// 29 - ANGLE_FRAC_BITS below that and 0 at 29 and above. One transfer is
// accepted per cycle while the pipeline is not held by a stall, set by the
// CORDIC stages each taking one iteration per register.
// m_tuser flags a degenerate case (coincident circles or undefined points);
// the angles are then zero.
// Reset clears all valid bits; payload registers are not reset.
// When the receiver stalls, the whole pipeline holds and s_tready drops
// while the output register holds a transfer that the receiver does not
// take; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module great_circle_intersection #(
    parameter int ANGLE_FRAC_BITS = 28
) (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata, from bit 0: azimuth_first_a(31), polar_first_a(30),
    // azimuth_first_b(31), polar_first_b(30), azimuth_second_a(31),
    // polar_second_a(30), azimuth_second_b(31), polar_second_b(30), zero pad(4)
    input  logic [247:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // m_tdata, from bit 0: cross_azimuth(31), cross_polar(30), zero pad(3)
    output logic [63:0]  m_tdata,
    // m_tuser: degenerate(1)
    output logic         m_tuser,
    output logic         m_tvalid,
    input  logic         m_tready
);

    localparam int VW = gci_pkg::VW;
    localparam int DW = gci_pkg::DW;

    // Widest scaled input decides how many modulo stages are needed.
    localparam int SW31       = 31 + ((30 - ANGLE_FRAC_BITS > 0) ? 30 - ANGLE_FRAC_BITS : 0);
    localparam int RED_STAGES = (SW31 > 32) ? SW31 - 32 : 0;
    localparam int LAT        = RED_STAGES + 109;

    localparam int OUT_UPP = (ANGLE_FRAC_BITS - 30 > 0) ? ANGLE_FRAC_BITS - 30 : 0;
    localparam int OUT_DNN = (30 - ANGLE_FRAC_BITS > 0) ? 30 - ANGLE_FRAC_BITS : 0;
    localparam int OWD     = gci_pkg::AW + OUT_UPP + 1;
    typedef logic signed [OWD-1:0] ow_t;
    localparam ow_t PI_OUT = (ow_t'(gci_pkg::Q_ONE_PI) <<< OUT_UPP) >>> OUT_DNN;

    logic en;
    logic [LAT-1:0] vld_reg;

    // The pipeline advances whenever the output register is free or drained.
    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // Points to unit vectors.
    gci_pkg::vec_t          pt_vec [4][3];
    logic signed [2*VW-1:0] pcx_reg [4];
    logic signed [2*VW-1:0] pcy_reg [4];
    gci_pkg::vec_t          nct_reg [4];

    for (genvar p = 0; p < 4; p++) begin : g_point
        gci_pkg::ang_t az_z, po_z;
        logic          az_n, po_n;
        gci_pkg::vec_t cp, sp, ct, st;

        gci_angle_reduce #(.IN_W(31), .FRAC(ANGLE_FRAC_BITS), .STAGES(RED_STAGES)) u_red_az (
            .aclk    (aclk),
            .en      (en),
            .angle   (s_tdata[61*p +: 31]),
            .z_out   (az_z),
            .neg_out (az_n)
        );

        gci_angle_reduce #(.IN_W(30), .FRAC(ANGLE_FRAC_BITS), .STAGES(RED_STAGES)) u_red_po (
            .aclk    (aclk),
            .en      (en),
            .angle   (s_tdata[61*p+31 +: 30]),
            .z_out   (po_z),
            .neg_out (po_n)
        );

        gci_sincos u_sc_az (
            .aclk    (aclk),
            .en      (en),
            .z_in    (az_z),
            .neg_in  (az_n),
            .cos_out (cp),
            .sin_out (sp)
        );

        gci_sincos u_sc_po (
            .aclk    (aclk),
            .en      (en),
            .z_in    (po_z),
            .neg_in  (po_n),
            .cos_out (ct),
            .sin_out (st)
        );

        always_ff @(posedge aclk) begin
            if (en) begin
                pcx_reg[p] <= st * cp;
                pcy_reg[p] <= st * sp;
                nct_reg[p] <= -ct;
            end
        end

        assign pt_vec[p][0] = VW'(pcx_reg[p] >>> 30);
        assign pt_vec[p][1] = VW'(pcy_reg[p] >>> 30);
        assign pt_vec[p][2] = nct_reg[p];
    end

    // Circle normals and the intersection direction.
    gci_pkg::vec_t  n_one [3];
    gci_pkg::vec_t  n_two [3];
    gci_pkg::dvec_t dir   [3];

    gci_cross #(.IW(VW), .OW(VW)) u_cross_one (
        .aclk  (aclk),
        .en    (en),
        .a_in  (pt_vec[0]),
        .b_in  (pt_vec[1]),
        .r_out (n_one)
    );

    gci_cross #(.IW(VW), .OW(VW)) u_cross_two (
        .aclk  (aclk),
        .en    (en),
        .a_in  (pt_vec[2]),
        .b_in  (pt_vec[3]),
        .r_out (n_two)
    );

    gci_cross #(.IW(VW), .OW(DW)) u_cross_dir (
        .aclk  (aclk),
        .en    (en),
        .a_in  (n_one),
        .b_in  (n_two),
        .r_out (dir)
    );

    // Normalization: magnitudes, their maximum, then a binary search of left
    // shifts (16, 8, 4, 2, 1) until the largest magnitude reaches 2^29. A
    // shift is taken only when it keeps the largest magnitude below 2^30.
    gci_pkg::dvec_t da_reg [3];
    logic [DW-1:0]  aa_reg [3];
    logic           dga_reg;
    gci_pkg::dvec_t db_reg [3];
    logic [DW-1:0]  bb_reg;
    logic           dgb_reg;
    gci_pkg::dvec_t ds_reg [5][3];
    logic [DW-1:0]  bs_reg [5];
    logic           dgs_reg [5];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                da_reg[c] <= dir[c];
                aa_reg[c] <= (dir[c] < 0) ? DW'(-dir[c]) : DW'(dir[c]);
            end
            dga_reg <= (dir[0] == '0) && (dir[1] == '0) && (dir[2] == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            db_reg  <= da_reg;
            dgb_reg <= dga_reg;
            if (aa_reg[0] >= aa_reg[1] && aa_reg[0] >= aa_reg[2]) begin
                bb_reg <= aa_reg[0];
            end else if (aa_reg[1] >= aa_reg[2]) begin
                bb_reg <= aa_reg[1];
            end else begin
                bb_reg <= aa_reg[2];
            end
        end
    end

    for (genvar j = 0; j < 5; j++) begin : g_norm
        localparam int SH = 16 >> j;
        localparam logic [DW-1:0] LIMIT = DW'(64'd1 << (30 - SH));
        gci_pkg::dvec_t di [3];
        logic [DW-1:0]  bi;
        logic           gi;
        if (j == 0) begin : g_first
            assign di = db_reg;
            assign bi = bb_reg;
            assign gi = dgb_reg;
        end else begin : g_next
            assign di = ds_reg[j-1];
            assign bi = bs_reg[j-1];
            assign gi = dgs_reg[j-1];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                dgs_reg[j] <= gi;
                if (bi < LIMIT) begin
                    bs_reg[j] <= bi << SH;
                    for (int c = 0; c < 3; c++) begin
                        ds_reg[j][c] <= di[c] <<< SH;
                    end
                end else begin
                    bs_reg[j] <= bi;
                    ds_reg[j] <= di;
                end
            end
        end
    end

    // Azimuth from (x, y); the z component and the flag ride along.
    gci_pkg::side_az_t sb_az_in, sb_az_out;
    gci_pkg::ang_t     phi_q;
    gci_pkg::dvec_t    len_xy;

    assign sb_az_in.deg = dgs_reg[4];
    assign sb_az_in.z   = ds_reg[4][2];

    gci_vec_cordic #(.SBW($bits(gci_pkg::side_az_t))) u_vec_az (
        .aclk    (aclk),
        .en      (en),
        .x_in    (ds_reg[4][0]),
        .y_in    (ds_reg[4][1]),
        .sb_in   (sb_az_in),
        .ang_out (phi_q),
        .len_out (len_xy),
        .sb_out  (sb_az_out)
    );

    // Remove the CORDIC gain from the horizontal length.
    logic signed [DW+31:0] rp_reg;
    gci_pkg::dvec_t        nz_reg;
    gci_pkg::side_po_t     sb_po_reg;
    gci_pkg::ang_t         theta_q;
    gci_pkg::dvec_t        len_unused;
    gci_pkg::side_po_t     sb_po_out;

    always_ff @(posedge aclk) begin
        if (en) begin
            rp_reg        <= len_xy * $signed({1'b0, gci_pkg::Q_INV_GAIN});
            nz_reg        <= -sb_az_out.z;
            sb_po_reg.deg <= sb_az_out.deg;
            sb_po_reg.phi <= phi_q;
        end
    end

    gci_vec_cordic #(.SBW($bits(gci_pkg::side_po_t))) u_vec_po (
        .aclk    (aclk),
        .en      (en),
        .x_in    (nz_reg),
        .y_in    (DW'(rp_reg >>> 30)),
        .sb_in   (sb_po_reg),
        .ang_out (theta_q),
        .len_out (len_unused),
        .sb_out  (sb_po_out)
    );

    // Clamp, rescale to the output format and clamp again, since the floor on
    // a right shift can push a negative azimuth just past -pi.
    logic [63:0] tdata_reg, tdata_next;
    logic        tuser_reg, tuser_next;

    always_comb begin
        gci_pkg::ang_t phi_c, theta_c;
        ow_t           phi_w, theta_w;
        phi_c = sb_po_out.phi;
        if (phi_c > gci_pkg::Q_ONE_PI)  phi_c = gci_pkg::Q_ONE_PI;
        if (phi_c < -gci_pkg::Q_ONE_PI) phi_c = -gci_pkg::Q_ONE_PI;
        theta_c = theta_q;
        if (theta_c > gci_pkg::Q_ONE_PI) theta_c = gci_pkg::Q_ONE_PI;
        if (theta_c < 0)                 theta_c = '0;
        phi_w   = (ow_t'(phi_c) <<< OUT_UPP) >>> OUT_DNN;
        theta_w = (ow_t'(theta_c) <<< OUT_UPP) >>> OUT_DNN;
        if (phi_w > PI_OUT)   phi_w = PI_OUT;
        if (phi_w < -PI_OUT)  phi_w = -PI_OUT;
        if (theta_w > PI_OUT) theta_w = PI_OUT;
        if (theta_w < 0)      theta_w = '0;
        if (sb_po_out.deg) begin
            tdata_next = '0;
            tuser_next = 1'b1;
        end else begin
            tdata_next = {3'b000, theta_w[29:0], phi_w[30:0]};
            tuser_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tdata_reg <= tdata_next;
            tuser_reg <= tuser_next;
        end
    end

    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tvalid = vld_reg[LAT-1];

`ifndef SYNTHESIS
    a_stall_link: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output register occupancy");

    a_degenerate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[60:0] == '0))
        else $error("degenerate result carries nonzero angles");
`endif

endmodule
